[src/smi_pkg.sv]
// shared widths, types and constants for the small matrix inverse block
package smi_pkg;

  localparam int EW        = 24;
  localparam int ADJ_W     = 2 * EW + 1;
  localparam int ADJ_LO    = EW + 1;
  localparam int DET_W     = 3 * EW + 2;
  localparam int INV_W     = 32;
  localparam int DETO_W    = 48;
  localparam int FRAC_W    = 16;
  localparam int DIV_STEPS = INV_W;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int NSTG      = 6 + DIV_STEPS + 1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SINGULAR = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  localparam logic [1:0] SIZE_1 = 2'd1;
  localparam logic [1:0] SIZE_2 = 2'd2;
  localparam logic [1:0] SIZE_3 = 2'd3;

  // cofactor k = m[XA]*m[XB] - m[XC]*m[XD], entries indexed column*3+row
  localparam int XA [9] = '{4, 2, 1, 6, 0, 3, 3, 6, 0};
  localparam int XB [9] = '{8, 7, 5, 5, 8, 2, 7, 1, 4};
  localparam int XC [9] = '{7, 1, 2, 3, 2, 0, 6, 0, 3};
  localparam int XD [9] = '{5, 8, 4, 8, 6, 5, 4, 7, 1};

  typedef logic signed [EW-1:0]    elem_t;
  typedef logic signed [ADJ_W-1:0] adj_t;
  typedef logic signed [DET_W-1:0] det_t;

  typedef struct packed {
    logic [8:0][EW-1:0] m;
    logic [1:0]         n;
    logic               last;
  } item_t;

  typedef struct packed {
    logic              zero;
    logic              dneg;
    logic              last;
    logic [8:0]        neg;
    logic [8:0]        big;
    logic [DETO_W-1:0] dmag;
  } div_side_t;

endpackage

[src/smi_front.sv]
// front end: request intake, size register and masking of unused entries
module smi_front
  import smi_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  logic [8:0][EW-1:0] in_m,
  input  logic            in_last,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_matrix_size,
  output logic            q_push,
  output item_t           q_item,
  input  logic            q_full
);

  logic [1:0] size_reg_r;
  logic [1:0] n;
  logic       v_r, v_nxt;
  logic       accept;
  item_t      item_r, item_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_reg_r <= SIZE_3;
    end else if (cfg_valid && cfg_ready) begin
      size_reg_r <= cfg_matrix_size;
    end
  end

  assign n = (size_reg_r == 2'd0) ? SIZE_1 : size_reg_r;

  assign in_full = v_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_push  = v_r && !q_full;
  assign q_item  = item_r;

  always_comb begin
    item_nxt.n    = n;
    item_nxt.last = in_last;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        // entries outside the active order read as zero
        item_nxt.m[c*3+r] = (r < int'(n) && c < int'(n)) ? in_m[c*3+r] : '0;
      end
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (accept) begin
      v_nxt = 1'b1;
    end else if (q_push) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

[src/smi_queue.sv]
// short queue between the front end and the arithmetic pipeline
module smi_queue
  import smi_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wdata,
  output logic  full,
  input  logic  pop,
  output item_t rdata,
  output logic  empty
);

  item_t               mem [QDEPTH];
  logic [QPTR_W-1:0]   wp_r, rp_r;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full    = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= wdata;
    end
  end

endmodule

[src/smi_div.sv]
// pipelined restoring divider, nine lanes sharing one divisor, one bit per stage
module smi_div
  import smi_pkg::*;
(
  input  logic                   clk,
  input  logic                   en,
  input  logic [DET_W-1:0]       d_in,
  input  logic [8:0][DET_W-1:0]  r_in,
  input  div_side_t              side_in,
  output logic [8:0][INV_W-1:0]  q_out,
  output div_side_t              side_out
);

  logic [DET_W-1:0]      d_r   [DIV_STEPS];
  logic [8:0][DET_W-1:0] r_r   [DIV_STEPS];
  logic [8:0][INV_W-1:0] q_r   [DIV_STEPS];
  div_side_t             side_r[DIV_STEPS];
  logic [8:0][DET_W-1:0] r_nxt [DIV_STEPS];
  logic [8:0][INV_W-1:0] q_nxt [DIV_STEPS];

  // stage inputs: the pipeline input for the first stage, the previous stage otherwise
  logic [DET_W-1:0]      d_src   [DIV_STEPS];
  logic [8:0][DET_W-1:0] r_src   [DIV_STEPS];
  logic [8:0][INV_W-1:0] q_src   [DIV_STEPS];
  div_side_t             side_src[DIV_STEPS];

  always_comb begin
    d_src[0]    = d_in;
    r_src[0]    = r_in;
    q_src[0]    = '0;
    side_src[0] = side_in;
    for (int s = 1; s < DIV_STEPS; s++) begin
      d_src[s]    = d_r[s-1];
      r_src[s]    = r_r[s-1];
      q_src[s]    = q_r[s-1];
      side_src[s] = side_r[s-1];
    end
  end

  always_comb begin
    logic [DET_W-1:0] dp;
    logic [DET_W-1:0] rp;
    logic [INV_W-1:0] qp;
    logic [DET_W:0]   sh;
    logic [DET_W:0]   df;
    for (int s = 0; s < DIV_STEPS; s++) begin
      dp = d_src[s];
      for (int k = 0; k < 9; k++) begin
        rp = r_src[s][k];
        qp = q_src[s][k];
        sh = {rp, 1'b0};
        df = sh - {1'b0, dp};
        if (sh >= {1'b0, dp}) begin
          r_nxt[s][k] = df[DET_W-1:0];
          q_nxt[s][k] = {qp[INV_W-2:0], 1'b1};
        end else begin
          r_nxt[s][k] = sh[DET_W-1:0];
          q_nxt[s][k] = {qp[INV_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_STEPS; s++) begin
        d_r[s]    <= d_src[s];
        side_r[s] <= side_src[s];
        r_r[s]    <= r_nxt[s];
        q_r[s]    <= q_nxt[s];
      end
    end
  end

  assign q_out    = q_r[DIV_STEPS-1];
  assign side_out = side_r[DIV_STEPS-1];

endmodule

[src/smi_back.sv]
// back end: cofactors, determinant, division and saturation into the result register
module smi_back
  import smi_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  item_t                  q_item,
  input  logic                   q_empty,
  output logic                   q_pop,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic [8:0][INV_W-1:0]  out_inv,
  output logic [DETO_W-1:0]      out_det,
  output logic [1:0]             out_status,
  output logic                   out_last
);

  logic [NSTG-1:0] v_r;
  logic            adv;

  // stage 1: cross products
  logic signed [2*EW-1:0] pa_r [9];
  logic signed [2*EW-1:0] pb_r [9];
  item_t                  s1_r;

  // stage 2: adjugate
  adj_t       adj2_r [9];
  adj_t       dsm2_r;
  elem_t      e_r [3];
  logic [1:0] n2_r;
  logic       last2_r;
  adj_t       adj2_nxt [9];
  adj_t       dsm2_nxt;

  // stage 3: determinant partial products
  logic signed [2*EW-1:0] ph_r [3];
  logic signed [2*EW+1:0] pl_r [3];
  adj_t       adj3_r [9];
  adj_t       dsm3_r;
  logic [1:0] n3_r;
  logic       last3_r;

  // stage 4: per-term sums
  det_t       t_r [3];
  adj_t       adj4_r [9];
  adj_t       dsm4_r;
  logic [1:0] n4_r;
  logic       last4_r;

  // stage 5: determinant
  det_t       det_r;
  adj_t       adj5_r [9];
  logic [1:0] n5_r;
  logic       last5_r;

  // stage 6: magnitudes and signs
  logic [DET_W-1:0]      dmag_r;
  logic [8:0][DET_W-1:0] r0_r;
  div_side_t             side6_r;
  logic [DET_W-1:0]      dmag_nxt;
  logic [8:0][DET_W-1:0] r0_nxt;
  div_side_t             side6_nxt;
  logic [DET_W-1:0]      dsh;

  logic [8:0][INV_W-1:0] q_div;
  div_side_t             side_div;

  logic [8:0][INV_W-1:0] inv_r, inv_nxt;
  logic [DETO_W-1:0]     det_o_r, det_o_nxt;
  logic [1:0]            st_r, st_nxt;
  logic                  last_o_r;

  assign adv       = !v_r[NSTG-1] || out_pop;
  assign q_pop     = adv && !q_empty;
  assign out_empty = !v_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NSTG-2:0], !q_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= q_item;
      for (int k = 0; k < 9; k++) begin
        pa_r[k] <= $signed(q_item.m[XA[k]]) * $signed(q_item.m[XB[k]]);
        pb_r[k] <= $signed(q_item.m[XC[k]]) * $signed(q_item.m[XD[k]]);
      end
    end
  end

  always_comb begin
    adj_t cof [9];
    for (int k = 0; k < 9; k++) begin
      cof[k]      = ADJ_W'(pa_r[k]) - ADJ_W'(pb_r[k]);
      adj2_nxt[k] = '0;
    end
    case (s1_r.n)
      SIZE_1: begin
        adj2_nxt[0] = ADJ_W'(1);
        dsm2_nxt    = ADJ_W'($signed(s1_r.m[0]));
      end
      SIZE_2: begin
        adj2_nxt[0] = ADJ_W'($signed(s1_r.m[4]));
        adj2_nxt[1] = -ADJ_W'($signed(s1_r.m[1]));
        adj2_nxt[3] = -ADJ_W'($signed(s1_r.m[3]));
        adj2_nxt[4] = ADJ_W'($signed(s1_r.m[0]));
        dsm2_nxt    = cof[8];
      end
      default: begin
        for (int k = 0; k < 9; k++) begin
          adj2_nxt[k] = cof[k];
        end
        dsm2_nxt = cof[8];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      adj2_r  <= adj2_nxt;
      dsm2_r  <= dsm2_nxt;
      e_r[0]  <= $signed(s1_r.m[0]);
      e_r[1]  <= $signed(s1_r.m[3]);
      e_r[2]  <= $signed(s1_r.m[6]);
      n2_r    <= s1_r.n;
      last2_r <= s1_r.last;
    end
  end

  // first row expansion, adjugate split into a signed high and unsigned low part
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ph_r[i] <= e_r[i] * $signed(adj2_r[i][ADJ_W-1:ADJ_LO]);
        pl_r[i] <= e_r[i] * $signed({1'b0, adj2_r[i][ADJ_LO-1:0]});
      end
      adj3_r  <= adj2_r;
      dsm3_r  <= dsm2_r;
      n3_r    <= n2_r;
      last3_r <= last2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        t_r[i] <= (DET_W'(ph_r[i]) <<< ADJ_LO) + DET_W'(pl_r[i]);
      end
      adj4_r  <= adj3_r;
      dsm4_r  <= dsm3_r;
      n4_r    <= n3_r;
      last4_r <= last3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      det_r   <= (n4_r == SIZE_3) ? (t_r[0] + t_r[1] + t_r[2]) : DET_W'(dsm4_r);
      adj5_r  <= adj4_r;
      n5_r    <= n4_r;
      last5_r <= last4_r;
    end
  end

  always_comb begin
    logic [ADJ_W-1:0] amag;
    logic             dneg;
    dneg     = det_r[DET_W-1];
    dmag_nxt = dneg ? DET_W'(-det_r) : DET_W'(det_r);
    for (int k = 0; k < 9; k++) begin
      amag              = adj5_r[k][ADJ_W-1] ? ADJ_W'(-adj5_r[k]) : ADJ_W'(adj5_r[k]);
      r0_nxt[k]         = DET_W'(amag);
      side6_nxt.neg[k]  = adj5_r[k][ADJ_W-1] ^ dneg;
      // quotient at or above 2^32 always saturates
      side6_nxt.big[k]  = DET_W'(amag) >= dmag_nxt;
    end
    case (n5_r)
      SIZE_1:  dsh = dmag_nxt;
      SIZE_2:  dsh = dmag_nxt >> FRAC_W;
      default: dsh = dmag_nxt >> (2 * FRAC_W);
    endcase
    side6_nxt.dmag = dsh[DETO_W-1:0];
    side6_nxt.zero = (det_r == '0);
    side6_nxt.dneg = dneg;
    side6_nxt.last = last5_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dmag_r  <= dmag_nxt;
      r0_r    <= r0_nxt;
      side6_r <= side6_nxt;
    end
  end

  smi_div u_div (
    .clk      (clk),
    .en       (adv),
    .d_in     (dmag_r),
    .r_in     (r0_r),
    .side_in  (side6_r),
    .q_out    (q_div),
    .side_out (side_div)
  );

  always_comb begin
    logic [8:0] sat;
    logic [INV_W-1:0] q;
    for (int k = 0; k < 9; k++) begin
      q = q_div[k];
      if (!side_div.neg[k]) begin
        sat[k]     = side_div.big[k] || q[INV_W-1];
        inv_nxt[k] = sat[k] ? {1'b0, {(INV_W-1){1'b1}}} : q;
      end else begin
        sat[k]     = side_div.big[k] || (q[INV_W-1] && (q[INV_W-2:0] != '0));
        inv_nxt[k] = sat[k] ? {1'b1, {(INV_W-1){1'b0}}} : -q;
      end
    end
    if (side_div.zero) begin
      inv_nxt   = '0;
      det_o_nxt = '0;
      st_nxt    = ST_SINGULAR;
    end else begin
      det_o_nxt = side_div.dneg ? -side_div.dmag : side_div.dmag;
      st_nxt    = (sat != '0) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inv_r    <= inv_nxt;
      det_o_r  <= det_o_nxt;
      st_r     <= st_nxt;
      last_o_r <= side_div.last;
    end
  end

  assign out_inv    = inv_r;
  assign out_det    = det_o_r;
  assign out_status = st_r;
  assign out_last   = last_o_r;

endmodule

[src/small_matrix_inverse.sv]
// top level of the small matrix inverse block
// Takes one 1x1, 2x2 or 3x3 matrix per cycle while in_full is low (order from
// cfg_matrix_size, applied to requests accepted after the write) and returns its
// Q32.16 determinant and its Q16.16 inverse, rounded toward zero and saturated, one
// result per request in order. A request passes through the intake register and the
// queue, then through a six-stage cofactor and determinant pipeline, the 32-stage
// bit-per-stage divider pipeline and the result register. Both sides behave as
// queues: a four-deep queue sits between the intake stage and the arithmetic
// pipeline, and the pipeline holds while the oldest result waits for out_pop.
module small_matrix_inverse
  import smi_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic signed [EW-1:0]     in_m11,
  input  logic signed [EW-1:0]     in_m21,
  input  logic signed [EW-1:0]     in_m31,
  input  logic signed [EW-1:0]     in_m12,
  input  logic signed [EW-1:0]     in_m22,
  input  logic signed [EW-1:0]     in_m32,
  input  logic signed [EW-1:0]     in_m13,
  input  logic signed [EW-1:0]     in_m23,
  input  logic signed [EW-1:0]     in_m33,
  input  logic                     in_last_matrix,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic signed [INV_W-1:0]  out_inv11,
  output logic signed [INV_W-1:0]  out_inv21,
  output logic signed [INV_W-1:0]  out_inv31,
  output logic signed [INV_W-1:0]  out_inv12,
  output logic signed [INV_W-1:0]  out_inv22,
  output logic signed [INV_W-1:0]  out_inv32,
  output logic signed [INV_W-1:0]  out_inv13,
  output logic signed [INV_W-1:0]  out_inv23,
  output logic signed [INV_W-1:0]  out_inv33,
  output logic signed [DETO_W-1:0] out_determinant,
  output logic [1:0]               out_status,
  output logic                     out_last_result,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_matrix_size
);

  logic [8:0][EW-1:0]    in_m;
  logic                  q_push, q_full, q_pop, q_empty;
  item_t                 q_wdata, q_rdata;
  logic [8:0][INV_W-1:0] inv;

  assign in_m = {in_m33, in_m23, in_m13, in_m32, in_m22, in_m12, in_m31, in_m21, in_m11};

  smi_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_m            (in_m),
    .in_last         (in_last_matrix),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_matrix_size (cfg_matrix_size),
    .q_push          (q_push),
    .q_item          (q_wdata),
    .q_full          (q_full)
  );

  smi_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  smi_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_item     (q_rdata),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_inv    (inv),
    .out_det    (out_determinant),
    .out_status (out_status),
    .out_last   (out_last_result)
  );

  assign out_inv11 = inv[0];
  assign out_inv21 = inv[1];
  assign out_inv31 = inv[2];
  assign out_inv12 = inv[3];
  assign out_inv22 = inv[4];
  assign out_inv32 = inv[5];
  assign out_inv13 = inv[6];
  assign out_inv23 = inv[7];
  assign out_inv33 = inv[8];

endmodule
